/* rtl/afrng_pkg.sv */
// Package: constants, state type and helper functions for the additive feedback generator
`default_nettype none
package afrng_pkg;

  // Ring size and derived widths
  localparam int MaxDegree = 63;
  localparam int IdxW      = $clog2(MaxDegree);
  localparam int CntW      = $clog2(MaxDegree * 10);

  // Register map (index = byte address / 4)
  localparam int       AddrW      = 3;
  localparam logic     RegGenType = 1'b0;
  localparam logic [2:0] GenTypeReset = 3'd3;

  // Generator types
  localparam logic [2:0] TypeLcg = 3'd0;

  // LCG constants
  localparam logic [30:0] LcgMul = 31'd1103515245;
  localparam logic [30:0] LcgInc = 31'd12345;

  // Minimal-standard step: multiply by 16807 modulo 2^31 - 1
  localparam logic [14:0] SchA = 15'd16807;
  localparam logic [31:0] SchM = 32'd2147483647;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DRAW_RD,
    ST_DRAW_WR,
    ST_LCG_MUL,
    ST_LCG_WR,
    ST_SEED_INIT,
    ST_SEED_MUL,
    ST_SEED_FIX
  } afrng_state_t;

  // Degree of a type (0..4)
  function automatic int deg_of_int(input logic [2:0] t);
    int d;
    begin
      unique case (t)
        3'd1:    d = 7;
        3'd2:    d = 15;
        3'd3:    d = 31;
        3'd4:    d = 63;
        default: d = 1;
      endcase
      return d;
    end
  endfunction

  // Clamp the register value to a type that fits the ring
  function automatic logic [2:0] eff_type(input logic [2:0] v);
    logic [2:0] t;
    begin
      t = (v > 3'd4) ? 3'd4 : v;
      for (int k = 0; k < 4; k++) begin
        if (t > 3'd1 && deg_of_int(t) > MaxDegree) t = t - 3'd1;
      end
      return t;
    end
  endfunction

  function automatic logic [IdxW-1:0] degree(input logic [2:0] t);
    return IdxW'(deg_of_int(t));
  endfunction

  // Tap separation of a type
  function automatic logic [IdxW-1:0] separation(input logic [2:0] t);
    logic [IdxW-1:0] s;
    begin
      unique case (t)
        3'd1:    s = IdxW'(3);
        3'd2:    s = IdxW'(1);
        3'd3:    s = IdxW'(3);
        3'd4:    s = IdxW'(1);
        default: s = '0;
      endcase
      return s;
    end
  endfunction

  // Last index of the discard run: ten times the degree, minus one
  function automatic logic [CntW-1:0] discard_last(input logic [2:0] t);
    return CntW'(deg_of_int(t) * 10 - 1);
  endfunction

endpackage
`default_nettype wire

/* rtl/additive_feedback_rng.sv */
// Top level: additive feedback random number generator with iterative reseed sequencer
//
//  channel  | handshake              | payload
//  ---------+------------------------+----------------------------------------
//  in       | in_valid / in_ready    | in_func, in_seed_value
//  out      | out_valid / out_ready  | out_random_value, out_seed_done
//  cfg      | APB psel/penable/...   | generator_type at byte address 0
//
// A draw of types 1..4 runs ring read, add and write, then result; a draw of the
// LCG type runs read, multiply, add and write, then result. The ring, with two
// read ports and one write port, sets these steps.
// A reseed of types 1..4 fills degree-1 words (multiply by 16807, then fold
// the product modulo 2^31-1 and write) and then runs 10*degree draws.
// Reset (rst_n low, synchronous) clears the ring valid bits so the ring reads
// as zeros; no clearing pass is needed. in_ready is low while an item is in
// work and while an undelivered result would be overwritten.
`default_nettype none
module additive_feedback_rng (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // input channel
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic                              in_func,
  input  wire logic [31:0]                       in_seed_value,
  // result channel
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [30:0]                            out_random_value,
  output logic                                   out_seed_done,
  // configuration port
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [afrng_pkg::AddrW-1:0]       paddr,
  input  wire logic [31:0]                       pwdata,
  output logic [31:0]                            prdata,
  output logic                                   pready
);

  localparam int IdxW = afrng_pkg::IdxW;
  localparam int CntW = afrng_pkg::CntW;
  localparam int MaxDegree = afrng_pkg::MaxDegree;

  // Control and datapath registers
  afrng_pkg::afrng_state_t state_r, state_nxt;
  logic [2:0]      type_r, type_nxt;
  logic [IdxW-1:0] front_r, front_nxt;
  logic [IdxW-1:0] rear_r, rear_nxt;
  logic [IdxW-1:0] fill_r, fill_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            disc_r, disc_nxt;
  logic [31:0]     seed_r, seed_nxt;
  logic [31:0]     x_r, x_nxt;
  logic [46:0]     prod_r, prod_nxt;
  logic [30:0]     lcg_r, lcg_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [30:0]     out_val_r, out_val_nxt;
  logic            out_done_r, out_done_nxt;

  // Ring memory with valid bits
  logic [31:0]          ring_mem [0:MaxDegree-1];
  logic [MaxDegree-1:0] ring_vld_r;
  logic [31:0]          rd_a_r, rd_b_r;
  logic                 rdv_a_r, rdv_b_r;
  logic                 we;
  logic [IdxW-1:0]      wa, ra, rb;
  logic [31:0]          wd;

  // Derived values
  logic [2:0]      eff_t;
  logic [IdxW-1:0] deg, sep, fr_e, rr_e, fr_inc, rr_inc;
  logic [CntW-1:0] last_cnt;
  logic [31:0]     ring_a, ring_b, sum;
  logic [61:0]     lcg_full;
  logic [30:0]     lcg_val;
  logic [31:0]     fold;
  logic [31:0]     word, seed_fix;
  logic            cfg_wr, in_acc;
  logic            draw_done;
  logic [30:0]     draw_val;

  assign eff_t    = afrng_pkg::eff_type(type_r);
  assign deg      = afrng_pkg::degree(eff_t);
  assign sep      = afrng_pkg::separation(eff_t);
  assign last_cnt = afrng_pkg::discard_last(eff_t);

  // Keep indexes inside the active ring
  assign fr_e   = (front_r >= deg) ? '0 : front_r;
  assign rr_e   = (rear_r >= deg) ? '0 : rear_r;
  assign fr_inc = (fr_e + 1'b1 >= deg) ? '0 : fr_e + 1'b1;
  assign rr_inc = (rr_e + 1'b1 >= deg) ? '0 : rr_e + 1'b1;

  // Ring words, zero until first written
  assign ring_a = rdv_a_r ? rd_a_r : '0;
  assign ring_b = rdv_b_r ? rd_b_r : '0;
  assign sum    = ring_a + ring_b;

  // LCG product, low 31 bits only
  assign lcg_full = ring_a[30:0] * afrng_pkg::LcgMul;
  assign lcg_val  = lcg_r + afrng_pkg::LcgInc;

  // Fold the product modulo 2^31-1: high part added to low part, one correction
  assign fold = {1'b0, prod_r[30:0]} + {16'h0000, prod_r[46:31]};
  assign word = (fold >= afrng_pkg::SchM) ? fold - afrng_pkg::SchM : fold;

  assign seed_fix = (seed_r == '0) ? 32'd1 : seed_r;

  assign cfg_wr = psel && penable && pwrite && (paddr[2] == afrng_pkg::RegGenType);
  assign in_ready = (state_r == afrng_pkg::ST_IDLE) && (!out_valid_r || out_ready);
  assign in_acc   = in_valid && in_ready;

  // Sequencer: next state, datapath updates and ring access
  always_comb begin
    state_nxt     = state_r;
    type_nxt      = type_r;
    front_nxt     = front_r;
    rear_nxt      = rear_r;
    fill_nxt      = fill_r;
    cnt_nxt       = cnt_r;
    disc_nxt      = disc_r;
    seed_nxt      = seed_r;
    x_nxt         = x_r;
    prod_nxt      = prod_r;
    lcg_nxt       = lcg_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_val_nxt   = out_val_r;
    out_done_nxt  = out_done_r;
    we            = 1'b0;
    wa            = '0;
    wd            = '0;
    ra            = '0;
    rb            = '0;
    draw_done     = 1'b0;
    draw_val      = '0;

    unique case (state_r)
      afrng_pkg::ST_IDLE: begin
        // Take a config write or a new item
        if (cfg_wr) begin
          type_nxt  = pwdata[2:0];
          front_nxt = afrng_pkg::separation(afrng_pkg::eff_type(pwdata[2:0]));
          rear_nxt  = '0;
        end
        if (in_acc) begin
          seed_nxt = in_seed_value;
          disc_nxt = 1'b0;
          state_nxt = in_func ? afrng_pkg::ST_SEED_INIT : afrng_pkg::ST_DRAW_RD;
        end
      end
      afrng_pkg::ST_DRAW_RD: begin
        // Fetch the words for one draw
        if (eff_t == afrng_pkg::TypeLcg) begin
          ra        = '0;
          state_nxt = afrng_pkg::ST_LCG_MUL;
        end else begin
          ra        = fr_e;
          rb        = rr_e;
          state_nxt = afrng_pkg::ST_DRAW_WR;
        end
      end
      afrng_pkg::ST_DRAW_WR: begin
        // Add rear into front, write back, advance both indexes
        we        = 1'b1;
        wa        = fr_e;
        wd        = sum;
        front_nxt = fr_inc;
        rear_nxt  = rr_inc;
        draw_done = 1'b1;
        draw_val  = sum[31:1];
      end
      afrng_pkg::ST_LCG_MUL: begin
        lcg_nxt   = lcg_full[30:0];
        state_nxt = afrng_pkg::ST_LCG_WR;
      end
      afrng_pkg::ST_LCG_WR: begin
        we        = 1'b1;
        wa        = '0;
        wd        = {1'b0, lcg_val};
        draw_done = 1'b1;
        draw_val  = lcg_val;
      end
      afrng_pkg::ST_SEED_INIT: begin
        // Store the seed in word 0; start the fill, or finish at once for the LCG type
        we   = 1'b1;
        wa   = '0;
        wd   = seed_fix;
        if (eff_t == afrng_pkg::TypeLcg) begin
          out_valid_nxt = 1'b1;
          out_val_nxt   = '0;
          out_done_nxt  = 1'b1;
          state_nxt     = afrng_pkg::ST_IDLE;
        end else begin
          x_nxt     = seed_fix;
          fill_nxt  = IdxW'(1);
          state_nxt = afrng_pkg::ST_SEED_MUL;
        end
      end
      afrng_pkg::ST_SEED_MUL: begin
        // Multiply the current word by 16807
        prod_nxt  = x_r * afrng_pkg::SchA;
        state_nxt = afrng_pkg::ST_SEED_FIX;
      end
      afrng_pkg::ST_SEED_FIX: begin
        // Write the new word, then multiply again or start the discard run
        we = 1'b1;
        wa = fill_r;
        wd = word;
        if (fill_r == deg - 1'b1) begin
          front_nxt = sep;
          rear_nxt  = '0;
          cnt_nxt   = '0;
          disc_nxt  = 1'b1;
          state_nxt = afrng_pkg::ST_DRAW_RD;
        end else begin
          fill_nxt  = fill_r + 1'b1;
          x_nxt     = word;
          state_nxt = afrng_pkg::ST_SEED_MUL;
        end
      end
      default: state_nxt = afrng_pkg::ST_IDLE;
    endcase

    // Finish a draw: deliver it, or count it off the discard run
    if (draw_done) begin
      if (disc_r) begin
        if (cnt_r == last_cnt) begin
          disc_nxt      = 1'b0;
          out_valid_nxt = 1'b1;
          out_val_nxt   = '0;
          out_done_nxt  = 1'b1;
          state_nxt     = afrng_pkg::ST_IDLE;
        end else begin
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = afrng_pkg::ST_DRAW_RD;
        end
      end else begin
        out_valid_nxt = 1'b1;
        out_val_nxt   = draw_val;
        out_done_nxt  = 1'b0;
        state_nxt     = afrng_pkg::ST_IDLE;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= afrng_pkg::ST_IDLE;
      type_r      <= afrng_pkg::GenTypeReset;
      front_r     <= afrng_pkg::separation(afrng_pkg::eff_type(afrng_pkg::GenTypeReset));
      rear_r      <= '0;
      fill_r      <= '0;
      cnt_r       <= '0;
      disc_r      <= 1'b0;
      out_valid_r <= 1'b0;
      ring_vld_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      type_r      <= type_nxt;
      front_r     <= front_nxt;
      rear_r      <= rear_nxt;
      fill_r      <= fill_nxt;
      cnt_r       <= cnt_nxt;
      disc_r      <= disc_nxt;
      out_valid_r <= out_valid_nxt;
      if (we) ring_vld_r[wa] <= 1'b1;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    seed_r     <= seed_nxt;
    x_r        <= x_nxt;
    prod_r     <= prod_nxt;
    lcg_r      <= lcg_nxt;
    out_val_r  <= out_val_nxt;
    out_done_r <= out_done_nxt;
  end

  // Ring memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (we) ring_mem[wa] <= wd;
    rd_a_r  <= ring_mem[ra];
    rd_b_r  <= ring_mem[rb];
    rdv_a_r <= ring_vld_r[ra];
    rdv_b_r <= ring_vld_r[rb];
  end

  // Ports
  assign out_valid        = out_valid_r;
  assign out_random_value = out_val_r;
  assign out_seed_done    = out_done_r;
  assign pready           = 1'b1;
  assign prdata = (paddr[2] == afrng_pkg::RegGenType) ? {29'b0, type_r} : '0;

`ifndef SYNTHESIS
  // in_ready drops after every accept: no item finishes at once
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("in_ready high the cycle after an accept");

  // Reseed acknowledgements carry no number
  a_seed_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_seed_done |-> out_random_value == '0)
    else $error("seed_done result with nonzero value");

  // Front and rear indexes stay within the active ring
  a_front_range: assert property (@(posedge clk) disable iff (!rst_n)
    eff_t != afrng_pkg::TypeLcg |-> front_r < deg && rear_r < deg)
    else $error("ring index out of range");

  // Discard counter never runs past its end
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    disc_r |-> cnt_r <= last_cnt)
    else $error("discard counter overrun");

  // A result appears only on leaving work, never out of idle
  a_out_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r) != afrng_pkg::ST_IDLE)
    else $error("result raised without work");
`endif

endmodule
`default_nettype wire
